FILE: rtl/bgf_pkg.sv
package bgf_pkg;

   // Operation codes carried on req_tuser
   localparam logic [1:0] MODE_PUSH  = 2'd0;
   localparam logic [1:0] MODE_POP   = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   // Result status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_SHORT = 2'd3;

   // Largest bit count moved by one word; larger requests saturate
   localparam logic [5:0] MAX_COUNT = 6'd32;

   // Fixed request widths
   localparam int REQ_DATA_W = 40;
   localparam int REQ_USER_W = 2;

   // Controller to datapath
   typedef struct packed {
      logic load;        // latch request word and its verdict
      logic push_step;   // write one chunk into the store
      logic pop_step;    // take one chunk from the read data
      logic finish;      // commit counts, load output register
   } bgf_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic go_push;     // push accepted with bits to move
      logic go_pop;      // pop accepted with bits to move
      logic last_chunk;  // current chunk ends the transfer
      logic out_free;    // output register can take a result
   } bgf_sts_type;

endpackage

FILE: rtl/bgf_ctrl.sv
module bgf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  bgf_pkg::bgf_sts_type sts,
   output bgf_pkg::bgf_cmd_type cmd
);
   import bgf_pkg::*;

   typedef enum logic [2:0] {
      IDLE,
      PUSH,
      POP_RD,
      POP_CAP,
      FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and commands
   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      unique case (state_ff)
         IDLE: begin
            cmd.load = req_tvalid;
            if (req_tvalid) begin
               if (sts.go_push) begin
                  state_in = PUSH;
               end else if (sts.go_pop) begin
                  state_in = POP_RD;
               end else begin
                  state_in = FINISH;
               end
            end
         end
         PUSH: begin
            cmd.push_step = 1'b1;
            if (sts.last_chunk) begin
               state_in = FINISH;
            end
         end
         POP_RD: begin
            // read data for the current word lands at the end of this cycle
            state_in = POP_CAP;
         end
         POP_CAP: begin
            cmd.pop_step = 1'b1;
            state_in     = sts.last_chunk ? FINISH : POP_RD;
         end
         FINISH: begin
            cmd.finish = sts.out_free;
            if (sts.out_free) begin
               state_in = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   assign req_tready = (state_ff == IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/bgf_datapath.sv
module bgf_datapath #(
   parameter int STORE_BITS = 1024,
   parameter int WORD_BITS  = 32,
   localparam int PW        = $clog2(STORE_BITS),
   localparam int RSP_W     = ((PW + 36 + 7) / 8) * 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  bgf_pkg::bgf_cmd_type                cmd,
   output bgf_pkg::bgf_sts_type                sts,
   input  logic [bgf_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic [bgf_pkg::REQ_USER_W-1:0]      req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [RSP_W-1:0]                    rsp_tdata
);
   import bgf_pkg::*;

   localparam int STORE_WORDS = (STORE_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int WAW         = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
   localparam int OW          = $clog2(WORD_BITS);
   localparam int LW          = $clog2(WORD_BITS + 1);
   localparam int MW          = (LW > 6) ? LW : 6;
   localparam int XW          = (WORD_BITS > 32) ? WORD_BITS : 32;
   localparam int XLW         = WORD_BITS + 1;
   localparam int PAD_W       = RSP_W - (PW + 36);

   localparam logic [WAW-1:0] LAST_WORD = WAW'(STORE_WORDS - 1);
   localparam logic [LW-1:0]  LAST_LEN  = LW'(STORE_BITS - (STORE_WORDS - 1) * WORD_BITS);
   localparam logic [LW-1:0]  FULL_LEN  = LW'(WORD_BITS);
   localparam logic [PW-1:0]  CAP       = PW'(STORE_BITS - 1);

   // Bit store, one word per entry, written with a per-bit enable
   logic [WORD_BITS-1:0] mem [STORE_WORDS];
   logic [WORD_BITS-1:0] rd_data_ff;

   // Request fields
   logic [1:0]  req_mode;
   logic [31:0] req_bits;
   logic [5:0]  req_count;
   logic [5:0]  cnt_sat;
   logic [PW-1:0] cnt_w;

   // Verdict on the incoming word
   logic [1:0] eval_status;
   logic       go_push;
   logic       go_pop;

   // Item registers
   logic [1:0]  mode_ff, mode_in;
   logic [1:0]  status_ff, status_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [5:0]  rem_ff, rem_in;
   logic [5:0]  done_ff, done_in;
   logic [31:0] data_sr_ff, data_sr_in;
   logic [31:0] acc_ff, acc_in;

   // FIFO state
   logic [PW-1:0]  used_ff, used_in;
   logic [WAW-1:0] wr_word_ff, wr_word_in;
   logic [OW-1:0]  wr_off_ff, wr_off_in;
   logic [WAW-1:0] rd_word_ff, rd_word_in;
   logic [OW-1:0]  rd_off_ff, rd_off_in;

   // Output register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    out_status_ff, out_status_in;
   logic [31:0]   out_bits_ff, out_bits_in;
   logic [PW-1:0] out_used_ff, out_used_in;
   logic          out_full_ff, out_full_in;
   logic          out_empty_ff, out_empty_in;

   // Chunk unit
   logic [WAW-1:0]       sel_word;
   logic [OW-1:0]        sel_off;
   logic [LW-1:0]        word_len;
   logic [LW-1:0]        avail;
   logic [5:0]           chunk;
   logic [LW-1:0]        off_sum;
   logic                 word_end;
   logic [WAW-1:0]       next_word;
   logic [OW-1:0]        next_off;
   logic [WORD_BITS-1:0] low_mask;
   logic [WORD_BITS-1:0] wr_mask;
   logic [WORD_BITS-1:0] wr_data;
   logic [WORD_BITS-1:0] rd_bits;

   assign req_mode  = req_tuser;
   assign req_bits  = req_tdata[31:0];
   assign req_count = req_tdata[37:32];
   assign cnt_sat   = (req_count > MAX_COUNT) ? MAX_COUNT : req_count;
   assign cnt_w     = PW'(cnt_sat);

   // Accept decision against the current fill
   always_comb begin
      eval_status = ST_OK;
      go_push     = 1'b0;
      go_pop      = 1'b0;
      unique case (req_mode)
         MODE_PUSH: begin
            if (used_ff >= CAP || cnt_w > CAP - used_ff) begin
               eval_status = ST_FULL;
            end else begin
               go_push = (cnt_sat != 6'd0);
            end
         end
         MODE_POP: begin
            if (used_ff == '0) begin
               eval_status = ST_EMPTY;
            end else if (cnt_w > used_ff) begin
               eval_status = ST_SHORT;
            end else begin
               go_pop = (cnt_sat != 6'd0);
            end
         end
         default: ;
      endcase
   end

   // Chunk: bits left in the request, bounded by the end of the current word
   always_comb begin
      sel_word  = (mode_ff == MODE_PUSH) ? wr_word_ff : rd_word_ff;
      sel_off   = (mode_ff == MODE_PUSH) ? wr_off_ff : rd_off_ff;
      word_len  = (sel_word == LAST_WORD) ? LAST_LEN : FULL_LEN;
      avail     = word_len - LW'(sel_off);
      chunk     = (MW'(rem_ff) < MW'(avail)) ? rem_ff : 6'(avail);
      off_sum   = LW'(sel_off) + LW'(chunk);
      word_end  = (off_sum == word_len);
      if (word_end) begin
         next_word = (sel_word == LAST_WORD) ? '0 : sel_word + 1'b1;
         next_off  = '0;
      end else begin
         next_word = sel_word;
         next_off  = OW'(off_sum);
      end
      low_mask  = WORD_BITS'((XLW'(1) << chunk) - XLW'(1));
      wr_mask   = low_mask << sel_off;
      wr_data   = WORD_BITS'(XW'(data_sr_ff)) << sel_off;
      rd_bits   = (rd_data_ff >> sel_off) & low_mask;
   end

   assign sts.go_push    = go_push;
   assign sts.go_pop     = go_pop;
   assign sts.last_chunk = (rem_ff == chunk);
   assign sts.out_free   = !rsp_valid_ff || rsp_tready;

   // Next values
   always_comb begin
      mode_in       = mode_ff;
      status_in     = status_ff;
      cnt_in        = cnt_ff;
      rem_in        = rem_ff;
      done_in       = done_ff;
      data_sr_in    = data_sr_ff;
      acc_in        = acc_ff;
      used_in       = used_ff;
      wr_word_in    = wr_word_ff;
      wr_off_in     = wr_off_ff;
      rd_word_in    = rd_word_ff;
      rd_off_in     = rd_off_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      out_status_in = out_status_ff;
      out_bits_in   = out_bits_ff;
      out_used_in   = out_used_ff;
      out_full_in   = out_full_ff;
      out_empty_in  = out_empty_ff;

      if (cmd.load) begin
         mode_in    = req_mode;
         status_in  = eval_status;
         cnt_in     = cnt_sat;
         rem_in     = cnt_sat;
         done_in    = 6'd0;
         data_sr_in = req_bits;
         acc_in     = 32'd0;
      end

      if (cmd.push_step) begin
         rem_in     = rem_ff - chunk;
         done_in    = done_ff + chunk;
         data_sr_in = data_sr_ff >> chunk;
         wr_word_in = next_word;
         wr_off_in  = next_off;
      end

      if (cmd.pop_step) begin
         rem_in     = rem_ff - chunk;
         done_in    = done_ff + chunk;
         acc_in     = acc_ff | 32'(XW'(rd_bits) << done_ff);
         rd_word_in = next_word;
         rd_off_in  = next_off;
      end

      if (cmd.finish) begin
         unique case (mode_ff)
            MODE_PUSH:  if (status_ff == ST_OK) used_in = used_ff + PW'(cnt_ff);
            MODE_POP:   if (status_ff == ST_OK) used_in = used_ff - PW'(cnt_ff);
            MODE_CLEAR: used_in = '0;
            default: ;
         endcase
         // an empty FIFO always restarts at position zero
         if (used_in == '0) begin
            wr_word_in = '0;
            wr_off_in  = '0;
            rd_word_in = '0;
            rd_off_in  = '0;
         end
         rsp_valid_in  = 1'b1;
         out_status_in = status_ff;
         out_bits_in   = acc_ff;
         out_used_in   = used_in;
         out_full_in   = (used_in == CAP);
         out_empty_in  = (used_in == '0);
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         wr_word_ff   <= '0;
         wr_off_ff    <= '0;
         rd_word_ff   <= '0;
         rd_off_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         wr_word_ff   <= wr_word_in;
         wr_off_ff    <= wr_off_in;
         rd_word_ff   <= rd_word_in;
         rd_off_ff    <= rd_off_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      status_ff     <= status_in;
      cnt_ff        <= cnt_in;
      rem_ff        <= rem_in;
      done_ff       <= done_in;
      data_sr_ff    <= data_sr_in;
      acc_ff        <= acc_in;
      out_status_ff <= out_status_in;
      out_bits_ff   <= out_bits_in;
      out_used_ff   <= out_used_in;
      out_full_ff   <= out_full_in;
      out_empty_ff  <= out_empty_in;
   end

   // Store write, bit-enabled
   always_ff @(posedge clock) begin
      if (cmd.push_step) begin
         for (int b = 0; b < WORD_BITS; b++) begin
            if (wr_mask[b]) begin
               mem[wr_word_ff][b] <= wr_data[b];
            end
         end
      end
   end

   // Store read, registered
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_word_ff];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, out_empty_ff, out_full_ff, out_used_ff,
                        out_bits_ff, out_status_ff};

endmodule

FILE: rtl/bit_granular_fifo.sv
// Bit-granular FIFO: a circular store of single bits, STORE_BITS deep, of
// which STORE_BITS-1 can be occupied.
// Request channel (req_): req_tuser selects push, pop or clear; req_tdata
// carries up to 32 bits to push (first bit at bit 0) and a bit count,
// counts above 32 taken as 32.
// Response channel (rsp_): exactly one word per request with status,
// popped bits, bits stored afterwards and full / empty flags.
// The store is kept in words of WORD_BITS; a transfer is split into chunks
// that each stay inside one store word (one or two chunks for 32-bit words).
// Steps from one accepted request to the next: push: accept, PUSH per
//   chunk, FINISH; pop: accept, POP_RD and POP_CAP per chunk (registered
//   read port of the store), FINISH; refused requests, clear and zero
//   counts: accept, FINISH. The response turns valid as req_tready rises.
// Reset empties the FIFO and clears any pending response; store contents
// are not cleared, so there is no clearing pass.
// A stalled response stays in the output register; a new request is still
// accepted and processed, and waits for the register to free before its
// own response is loaded.
module bit_granular_fifo #(
   parameter int STORE_BITS = 1024,
   parameter int WORD_BITS  = 32,
   localparam int PW        = $clog2(STORE_BITS),
   localparam int RSP_W     = ((PW + 36 + 7) / 8) * 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // write_bits [31:0], bit_count [37:32], zero [39:38]
   input  logic [bgf_pkg::REQ_DATA_W-1:0] req_tdata,
   // mode [1:0]
   input  logic [bgf_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // status [1:0], read_bits [33:2], bits_used [PW+33:34],
   // is_full [PW+34], is_empty [PW+35], zero above
   output logic [RSP_W-1:0]               rsp_tdata
);
   import bgf_pkg::*;

   bgf_cmd_type cmd;
   bgf_sts_type sts;

   bgf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   bgf_datapath #(
      .STORE_BITS (STORE_BITS),
      .WORD_BITS  (WORD_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
